// ----- src/lpfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Length-prefixed frame parser package
// Shared types, role codes and phase encodings for the frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

  // Byte role codes as reported on the result channel.
  localparam logic [2:0] ROLE_CMD0  = 3'd0;
  localparam logic [2:0] ROLE_CMD1  = 3'd1;
  localparam logic [2:0] ROLE_FLAGS = 3'd2;
  localparam logic [2:0] ROLE_LEN0  = 3'd3;
  localparam logic [2:0] ROLE_LEN1  = 3'd4;
  localparam logic [2:0] ROLE_LEN2  = 3'd5;
  localparam logic [2:0] ROLE_LEN3  = 3'd6;
  localparam logic [2:0] ROLE_DATA  = 3'd7;

  // Request type codes.
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_ABORT = 1'b1;

  // Bit positions of the upper length bytes (little-endian).
  localparam int unsigned LenShift1 = 8;
  localparam int unsigned LenShift2 = 16;
  localparam int unsigned LenShift3 = 24;

  // Parser phase, one-hot.
  typedef enum logic [7:0] {
    PH_CMD0  = 8'b0000_0001,
    PH_CMD1  = 8'b0000_0010,
    PH_FLAGS = 8'b0000_0100,
    PH_LEN0  = 8'b0000_1000,
    PH_LEN1  = 8'b0001_0000,
    PH_LEN2  = 8'b0010_0000,
    PH_LEN3  = 8'b0100_0000,
    PH_DATA  = 8'b1000_0000
  } phase_e;

  // One input item as held in the input register.
  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  byte_role;
    logic [31:0] frame_length;
    logic [31:0] payload_index;
    logic        frame_last;
  } result_t;

endpackage

// ----- src/length_prefixed_frame_parser.sv -----
// ----------------------------------------------------------------------------
// Length-prefixed frame parser
// Splits a byte stream into frames of two command bytes, a flags byte, a
// 32-bit little-endian length and that many payload bytes.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer carries either a received byte (req_type_i low) or an
// abort (req_type_i high). Every received byte gives one result transfer with
// the byte, its role in the frame, the length assembled so far, its payload
// index and a frame-end mark. An abort gives no result and returns the parser
// to the first command byte.
// An accepted item sits in the input register while the parse step computes
// its result, which the result register takes once it is free.
// Throughput is one item per cycle while the receiver does not stall; the
// parse step is a single phase update plus one 32-bit increment and compare
// for the payload count.
// When the receiver stalls, the result register holds its transfer, the input
// register fills, and in_stall_o rises; aborts keep draining into the parse
// state while the result register is full.
// After reset both registers are empty and the parser expects a command byte.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  byte_role_o,
  output logic [31:0] frame_length_o,
  output logic [31:0] payload_index_o,
  output logic        frame_last_o
);
  import lpfp_pkg::*;

  item_t   item_in, item_q;
  logic    item_valid;
  logic    out_ready;
  logic    advance;
  logic    load_out;
  result_t step_res, out_res;

  assign item_in.req_type = req_type_i;
  assign item_in.rx_byte  = rx_byte_i;

  // Aborts never need the result register; bytes wait for it.
  assign advance  = item_valid && ((item_q.req_type == REQ_ABORT) || out_ready);
  assign load_out = advance && (item_q.req_type == REQ_BYTE);

  lpfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  lpfp_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .result_o (step_res)
  );

  lpfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load_out),
    .result_i    (step_res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign out_byte_o      = out_res.out_byte;
  assign byte_role_o     = out_res.byte_role;
  assign frame_length_o  = out_res.frame_length;
  assign payload_index_o = out_res.payload_index;
  assign frame_last_o    = out_res.frame_last;

endmodule

// ----- src/lpfp_in_stage.sv -----
// ----------------------------------------------------------------------------
// Frame parser input register
// Captures one input transfer and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module lpfp_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lpfp_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output lpfp_pkg::item_t item_o
);
  import lpfp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // The register can take a new transfer when it is empty or being drained.
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- src/lpfp_step.sv -----
// ----------------------------------------------------------------------------
// Frame parser step logic
// Holds the parse state and computes the result and next state of one item.
// ----------------------------------------------------------------------------
module lpfp_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  lpfp_pkg::item_t   item_i,
  output lpfp_pkg::result_t result_o
);
  import lpfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] length_q, length_d;
  logic [31:0] count_q, count_d;
  logic [31:0] byte_ext;
  logic [31:0] count_inc;
  result_t     res;

  assign byte_ext  = {24'd0, item_i.rx_byte};
  assign count_inc = count_q + 32'd1;

  // Role decode, length assembly and payload counting for the current byte.
  always_comb begin
    phase_d           = phase_q;
    length_d          = length_q;
    count_d           = count_q;
    res.out_byte      = item_i.rx_byte;
    res.byte_role     = ROLE_CMD0;
    res.frame_length  = 32'd0;
    res.payload_index = 32'd0;
    res.frame_last    = 1'b0;
    case (phase_q)
      PH_CMD0: begin
        res.byte_role = ROLE_CMD0;
        phase_d       = PH_CMD1;
      end
      PH_CMD1: begin
        res.byte_role = ROLE_CMD1;
        phase_d       = PH_FLAGS;
      end
      PH_FLAGS: begin
        res.byte_role = ROLE_FLAGS;
        phase_d       = PH_LEN0;
      end
      PH_LEN0: begin
        res.byte_role    = ROLE_LEN0;
        length_d         = byte_ext;
        res.frame_length = length_d;
        phase_d          = PH_LEN1;
      end
      PH_LEN1: begin
        res.byte_role    = ROLE_LEN1;
        length_d         = length_q | (byte_ext << LenShift1);
        res.frame_length = length_d;
        phase_d          = PH_LEN2;
      end
      PH_LEN2: begin
        res.byte_role    = ROLE_LEN2;
        length_d         = length_q | (byte_ext << LenShift2);
        res.frame_length = length_d;
        phase_d          = PH_LEN3;
      end
      PH_LEN3: begin
        res.byte_role    = ROLE_LEN3;
        length_d         = length_q | (byte_ext << LenShift3);
        res.frame_length = length_d;
        count_d          = 32'd0;
        // A zero length ends the frame on the last length byte.
        if (length_d == 32'd0) begin
          res.frame_last = 1'b1;
          phase_d        = PH_CMD0;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        res.byte_role     = ROLE_DATA;
        res.frame_length  = length_q;
        res.payload_index = count_q;
        if (count_inc == length_q) begin
          res.frame_last = 1'b1;
          phase_d        = PH_CMD0;
        end else begin
          count_d = count_inc;
        end
      end
      default: begin
        phase_d = PH_CMD0;
      end
    endcase
    // An abort returns the parser to its start.
    if (item_i.req_type == REQ_ABORT) begin
      phase_d  = PH_CMD0;
      length_d = 32'd0;
      count_d  = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_CMD0;
      length_q <= 32'd0;
      count_q  <= 32'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      count_q  <= count_d;
    end
  end

  assign result_o = res;

endmodule

// ----- src/lpfp_out_stage.sv -----
// ----------------------------------------------------------------------------
// Frame parser result register
// Holds one result transfer until the receiver takes it.
// ----------------------------------------------------------------------------
module lpfp_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  lpfp_pkg::result_t result_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lpfp_pkg::result_t result_o
);
  import lpfp_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // Free when empty or when the held result leaves this cycle.
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ----- src/lpfp_checker.sv -----
// ----------------------------------------------------------------------------
// Frame parser port checker
// Watches the top-level ports for result consistency and handshake rules.
// ----------------------------------------------------------------------------
module lpfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  byte_role_o,
  input logic [31:0] frame_length_o,
  input logic [31:0] payload_index_o,
  input logic        frame_last_o
);
  import lpfp_pkg::*;

  // A stalled result transfer stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  // Only a last length byte or a payload byte can end a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |->
      (byte_role_o == ROLE_LEN3) || (byte_role_o == ROLE_DATA))
    else $error("frame end on a header byte");

  // A frame that ends on its length byte has zero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o && (byte_role_o == ROLE_LEN3) |->
      frame_length_o == 32'd0)
    else $error("nonzero length ended on length byte");

  // The last payload byte sits at length minus one; others before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_role_o == ROLE_DATA) |->
      ((payload_index_o + 32'd1) == frame_length_o) == frame_last_o)
    else $error("payload index and frame end disagree");

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .byte_role_o     (byte_role_o),
  .frame_length_o  (frame_length_o),
  .payload_index_o (payload_index_o),
  .frame_last_o    (frame_last_o)
);

// ----- bench/tb_length_prefixed_frame_parser.sv -----
// ----------------------------------------------------------------------------
// Length-prefixed frame parser testbench
// Sends directed frames, then randomly built frames with aborts and noise into
// the parser. Random idle and stall bursts are applied on both channels. Every
// result transfer is checked against a frame decoder kept in the bench.
// ----------------------------------------------------------------------------
module tb_length_prefixed_frame_parser;
  import lpfp_pkg::*;

  localparam int unsigned TargetItems  = 1650;
  localparam int unsigned MaxIdleBurst = 18;
  localparam int unsigned QuietTail    = 120;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned DrainCycles  = 12;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned ShortFrame   = 16;
  localparam int unsigned LongFrame    = 80;
  localparam int unsigned CutPayload   = 40;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        req_type_i  = REQ_BYTE;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic [2:0]  byte_role_o;
  logic [31:0] frame_length_o;
  logic [31:0] payload_index_o;
  logic        frame_last_o;

  length_prefixed_frame_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_role_o     (byte_role_o),
    .frame_length_o  (frame_length_o),
    .payload_index_o (payload_index_o),
    .frame_last_o    (frame_last_o)
  );

  // Pending input transfers and results still owed by the parser.
  item_t       byte_stream[$];
  result_t     frame_results[$];

  // Decoder state kept by the bench.
  logic [2:0]  next_role = ROLE_CMD0;
  logic [31:0] len_sum   = '0;
  logic [31:0] pay_seen  = '0;

  // Handshake and pacing state.
  logic        in_took       = 1'b0;
  logic        out_took      = 1'b0;
  logic        tail          = 1'b0;
  logic        gap_owed      = 1'b0;
  int unsigned send_gap_left = 0;
  int unsigned recv_left     = 0;
  int unsigned send_pct      = 0;
  int unsigned recv_pct      = 0;
  int unsigned pace_cycles   = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatch_cnt  = 0;

  // Free-running clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Decode one accepted transfer and queue the result it should produce.
  task automatic predict_parse(input item_t it);
    result_t r;
    r = '0;
    if (it.req_type == REQ_ABORT) begin
      next_role = ROLE_CMD0;
      len_sum   = '0;
      pay_seen  = '0;
      return;
    end
    r.out_byte  = it.rx_byte;
    r.byte_role = next_role;
    case (next_role)
      ROLE_CMD0:  next_role = ROLE_CMD1;
      ROLE_CMD1:  next_role = ROLE_FLAGS;
      ROLE_FLAGS: next_role = ROLE_LEN0;
      ROLE_LEN0: begin
        len_sum        = {24'd0, it.rx_byte};
        r.frame_length = len_sum;
        next_role      = ROLE_LEN1;
      end
      ROLE_LEN1: begin
        len_sum        = len_sum | ({24'd0, it.rx_byte} << LenShift1);
        r.frame_length = len_sum;
        next_role      = ROLE_LEN2;
      end
      ROLE_LEN2: begin
        len_sum        = len_sum | ({24'd0, it.rx_byte} << LenShift2);
        r.frame_length = len_sum;
        next_role      = ROLE_LEN3;
      end
      ROLE_LEN3: begin
        len_sum        = len_sum | ({24'd0, it.rx_byte} << LenShift3);
        r.frame_length = len_sum;
        pay_seen       = '0;
        if (len_sum == 32'd0) begin
          r.frame_last = 1'b1;
          next_role    = ROLE_CMD0;
        end else begin
          next_role = ROLE_DATA;
        end
      end
      default: begin
        r.frame_length  = len_sum;
        r.payload_index = pay_seen;
        if (pay_seen + 32'd1 == len_sum) begin
          r.frame_last = 1'b1;
          next_role    = ROLE_CMD0;
        end else begin
          pay_seen = pay_seen + 32'd1;
        end
      end
    endcase
    frame_results.insert(frame_results.size(), r);
  endtask

  task automatic push_byte(input logic [7:0] b);
    item_t it;
    it = {REQ_BYTE, b};
    byte_stream.insert(byte_stream.size(), it);
  endtask

  task automatic push_abort();
    item_t it;
    it = {REQ_ABORT, 8'($urandom)};
    byte_stream.insert(byte_stream.size(), it);
  endtask

  // Two command bytes, a flags byte and the length, low byte first.
  task automatic push_header(input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] flags, input logic [31:0] len);
    push_byte(c0);
    push_byte(c1);
    push_byte(flags);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    push_byte(len[23:16]);
    push_byte(len[31:24]);
  endtask

  // One random frame. Some are cut short by an abort at a random byte, and
  // frames with very large lengths are always cut.
  task automatic add_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned total;
    int unsigned cut;
    logic        chop;
    kind = $urandom_range(99);
    if (kind < 10) begin
      len = 0;
    end else if (kind < 75) begin
      len = $urandom_range(ShortFrame, 1);
    end else if (kind < 93) begin
      len = $urandom_range(LongFrame, ShortFrame + 1);
    end else begin
      len = $urandom;
    end
    chop  = (len > LongFrame) || ($urandom_range(99) < 8);
    total = 7 + ((chop && len > CutPayload) ? CutPayload : len);
    cut   = $urandom_range(total - 1);
    for (int unsigned pos = 0; pos < total; pos++) begin
      if (chop && pos == cut) begin
        push_abort();
        return;
      end
      if (pos >= 3 && pos <= 6) begin
        push_byte(8'(len >> (8 * (pos - 3))));
      end else begin
        push_byte(8'($urandom));
      end
    end
  endtask

  // Idle rate for one pacing window: none, light, moderate or heavy.
  function automatic int unsigned pick_pct();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 5;
      2:       return 25;
      default: return 60;
    endcase
  endfunction

  // Sample both channels, decode accepted input and check every result.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    in_took  = rst_ni && in_valid_i && !in_stall_o;
    out_took = rst_ni && out_valid_o && !out_stall_i;
    if (in_took) begin
      predict_parse({req_type_i, rx_byte_i});
    end
    if (out_took) begin
      got = {out_byte_o, byte_role_o, frame_length_o, payload_index_o, frame_last_o};
      if (frame_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports) begin
          $display("unexpected result: byte %02h role %0d len %08h idx %08h last %0b",
                   got.out_byte, got.byte_role, got.frame_length, got.payload_index,
                   got.frame_last);
        end
      end else begin
        want = frame_results.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports) begin
            $display("mismatch (exp/got): byte %02h/%02h role %0d/%0d len %08h/%08h",
                     want.out_byte, got.out_byte, want.byte_role, got.byte_role,
                     want.frame_length, got.frame_length);
            $display("  idx %08h/%08h last %0b/%0b", want.payload_index,
                     got.payload_index, want.frame_last, got.frame_last);
          end
        end
      end
    end
    if (in_took || out_took) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  // Drive the input channel and the result stall at the falling edge.
  always @(negedge clk_i) begin
    logic  next_valid;
    logic  next_stall;
    item_t next_item;
    if (rst_ni) begin
      tail = (byte_stream.size() < QuietTail);
      if (pace_cycles % 256 == 0) begin
        send_pct = pick_pct();
        recv_pct = pick_pct();
      end
      pace_cycles++;

      // Sender: hold a stalled transfer, otherwise idle or load the next one.
      // A gap burst is always followed by a transfer.
      if (!in_valid_i || in_took) begin
        next_valid = 1'b0;
        next_item  = {req_type_i, rx_byte_i};
        if (send_gap_left != 0) begin
          send_gap_left--;
        end else if (!tail && !gap_owed && $urandom_range(99) < send_pct) begin
          send_gap_left = $urandom_range(MaxIdleBurst, 1) - 1;
          gap_owed      = 1'b1;
        end else if (byte_stream.size() != 0) begin
          next_item  = byte_stream.pop_front();
          next_valid = 1'b1;
          gap_owed   = 1'b0;
        end
        in_valid_i <= next_valid;
        req_type_i <= next_item.req_type;
        rx_byte_i  <= next_item.rx_byte;
      end

      // Receiver: stall bursts, with the stall released between bursts.
      if (recv_left != 0) begin
        recv_left--;
        next_stall = 1'b1;
      end else if (!tail && !out_stall_i && $urandom_range(99) < recv_pct) begin
        recv_left  = $urandom_range(MaxIdleBurst, 1) - 1;
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      out_stall_i <= next_stall;
    end
  end

  // Ends the run when neither channel moves for too long.
  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // Build the stimulus, release reset, and wait for the parser to drain.
  initial begin
    // Zero length: the last length byte closes the frame.
    push_header(8'h00, 8'hFF, 8'hA5, 32'h0000_0000);
    // One payload byte that closes the frame.
    push_header(8'hFF, 8'h00, 8'h5A, 32'h0000_0001);
    push_byte(8'hFF);
    // Largest length, cut off by an abort inside the payload.
    push_header(8'h12, 8'h34, 8'hFF, 32'hFFFF_FFFF);
    push_byte(8'h80);
    push_abort();

    // Mostly well-formed frames, with bursts of noise that end in an abort.
    while (byte_stream.size() < TargetItems) begin
      if ($urandom_range(99) < 5) begin
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(2) == 0) begin
            push_abort();
          end else begin
            push_byte(8'($urandom));
          end
        end
        push_abort();
      end else begin
        add_frame();
      end
    end

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_stream.size() != 0 || in_valid_i) @(posedge clk_i);
    while (frame_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/lpfp_pkg.sv
src/lpfp_in_stage.sv
src/lpfp_step.sv
src/lpfp_out_stage.sv
src/length_prefixed_frame_parser.sv
src/lpfp_checker.sv
bench/tb_length_prefixed_frame_parser.sv
